/* src/koch_curve_segment_generator_assert.svh */
// Assertion macros for the Koch curve segment generator checker.
// Both macros expect signals named clock and reset in the calling scope.
`ifndef KOCH_CURVE_SEGMENT_GENERATOR_ASSERT_SVH
`define KOCH_CURVE_SEGMENT_GENERATOR_ASSERT_SVH

// Property that must hold in the same cycle, ignored while reset is high.
`define KCSG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Property that must hold in the cycle after the antecedent.
`define KCSG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/kcsg_pkg.sv */
// Shared types, constants and the turn table of the Koch curve segment generator.
// No dependencies; the design files refer to this package by scoped names.
`default_nettype none

package kcsg_pkg;

   localparam int MaxDepthDefault   = 6;
   localparam int CoordWidthDefault = 32;

   // Width of the step length and of the scaled results (base_length is 31 bits)
   localparam int LenWidth   = 31;
   localparam int FieldWidth = 32;
   localparam int CsrIdxWidth = 3;

   // Configuration register indexes
   localparam logic [CsrIdxWidth-1:0] RegDepth      = 3'd0;
   localparam logic [CsrIdxWidth-1:0] RegMode       = 3'd1;
   localparam logic [CsrIdxWidth-1:0] RegStartX     = 3'd2;
   localparam logic [CsrIdxWidth-1:0] RegStartY     = 3'd3;
   localparam logic [CsrIdxWidth-1:0] RegBaseLength = 3'd4;

   // x / 3 == (x * Recip3) >> Recip3Shift for any 32-bit x
   localparam logic [31:0] Recip3      = 32'hAAAA_AAAB;
   localparam int          Recip3Shift = 33;
   // sqrt(3)/2 in Q0.16, rounded
   localparam logic [31:0] Sin60Q16    = 32'd56756;
   localparam logic [31:0] RoundHalf   = 32'd32768;
   localparam int          FracBits    = 16;

   // Heading turn between the two sides of the snowflake axiom
   localparam logic [2:0] TurnSnowSide = 3'd4;
   localparam logic [2:0] HeadingCount = 3'd6;

   typedef enum logic {
      OP_DIV3   = 1'b0,
      OP_HEIGHT = 1'b1
   } scale_op_type;

   typedef struct packed {
      logic clear;     // restart: zero digits, side and heading, clear finished
      logic advance;   // one segment drawn: move the digit counters, side, heading and finished
   } walk_ctl_type;

   typedef struct packed {
      logic [2:0] heading;
      logic       finished;
      logic       last;      // the current segment is the final one
   } walk_stat_type;

   // Heading increment after F number pos of the rule (pos 3 acts as pos 0)
   function automatic logic [2:0] rule_turn(input logic mode, input logic [1:0] pos);
      logic [2:0] t;
      case (pos)
         2'd1:    t = mode ? 3'd2 : 3'd4;
         default: t = mode ? 3'd5 : 3'd1;
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

/* src/kcsg_scale.sv */
// Shared multiply unit: divides the step length by three or forms its height.
// Depends on kcsg_pkg.
`default_nettype none

module kcsg_scale (
   input  wire kcsg_pkg::scale_op_type          op,
   input  wire logic [kcsg_pkg::LenWidth-1:0]   operand,
   output logic      [kcsg_pkg::LenWidth-1:0]   result
);

   localparam int ProdWidth = kcsg_pkg::LenWidth + 32;

   logic [31:0]          factor;
   logic [ProdWidth-1:0] prod;
   logic [ProdWidth-1:0] rounded;

   always_comb begin
      factor  = (op == kcsg_pkg::OP_DIV3) ? kcsg_pkg::Recip3 : kcsg_pkg::Sin60Q16;
      prod    = ProdWidth'(operand) * ProdWidth'(factor);
      rounded = prod + ProdWidth'(kcsg_pkg::RoundHalf);
      if (op == kcsg_pkg::OP_DIV3) begin
         result = kcsg_pkg::LenWidth'(prod >> kcsg_pkg::Recip3Shift);
      end else begin
         result = kcsg_pkg::LenWidth'(rounded >> kcsg_pkg::FracBits);
      end
   end

endmodule

`default_nettype wire

/* src/kcsg_walker.sv */
// Base-4 digit counters, side counter and heading of the curve walk.
// Depends on kcsg_pkg.
`default_nettype none

module kcsg_walker #(
   parameter int MAX_DEPTH = kcsg_pkg::MaxDepthDefault
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire kcsg_pkg::walk_ctl_type         ctl,
   input  wire logic [$clog2(MAX_DEPTH+1)-1:0] depth,
   input  wire logic                           mode,
   output kcsg_pkg::walk_stat_type             stat
);

   localparam int IdxWidth = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   logic [1:0]          digit_ff [MAX_DEPTH];
   logic [1:0]          digit_in [MAX_DEPTH];
   logic [1:0]          side_ff, side_in;
   logic [2:0]          heading_ff, heading_in;
   logic                finished_ff, finished_in;

   logic                found;
   logic [IdxWidth-1:0] pos;
   logic                side_done;
   logic [2:0]          turn;
   logic [3:0]          head_sum;

   // Find the innermost live digit that can still count up
   always_comb begin
      found = 1'b0;
      pos   = '0;
      for (int j = 0; j < MAX_DEPTH; j++) begin
         if (!found && (j < int'(depth)) && (digit_ff[j] != 2'd3)) begin
            found = 1'b1;
            pos   = IdxWidth'(j);
         end
      end
   end

   always_comb begin
      side_done = (3'(side_ff) + 3'd1) >= (mode ? 3'd4 : 3'd3);
      if (found) begin
         turn = kcsg_pkg::rule_turn(mode, digit_ff[pos]);
      end else if (side_done) begin
         turn = 3'd0;
      end else if (mode) begin
         turn = kcsg_pkg::rule_turn(mode, side_ff);
      end else begin
         turn = kcsg_pkg::TurnSnowSide;
      end
      head_sum = 4'(heading_ff) + 4'(turn);
      if (head_sum >= 4'(kcsg_pkg::HeadingCount)) begin
         head_sum = head_sum - 4'(kcsg_pkg::HeadingCount);
      end
   end

   always_comb begin
      for (int j = 0; j < MAX_DEPTH; j++) begin
         digit_in[j] = digit_ff[j];
      end
      side_in     = side_ff;
      heading_in  = heading_ff;
      finished_in = finished_ff;
      if (ctl.clear) begin
         for (int j = 0; j < MAX_DEPTH; j++) begin
            digit_in[j] = 2'd0;
         end
         side_in     = 2'd0;
         heading_in  = 3'd0;
         finished_in = 1'b0;
      end else if (ctl.advance) begin
         heading_in = 3'(head_sum);
         if (found) begin
            // carry: bump the found digit, zero all inner ones
            for (int j = 0; j < MAX_DEPTH; j++) begin
               if (IdxWidth'(j) < pos) begin
                  digit_in[j] = 2'd0;
               end else if (IdxWidth'(j) == pos) begin
                  digit_in[j] = digit_ff[j] + 2'd1;
               end
            end
         end else begin
            for (int j = 0; j < MAX_DEPTH; j++) begin
               digit_in[j] = 2'd0;
            end
            if (side_done) begin
               finished_in = 1'b1;
            end else begin
               side_in = side_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_DEPTH; j++) begin
            digit_ff[j] <= 2'd0;
         end
         side_ff     <= 2'd0;
         heading_ff  <= 3'd0;
         finished_ff <= 1'b1;
      end else begin
         for (int j = 0; j < MAX_DEPTH; j++) begin
            digit_ff[j] <= digit_in[j];
         end
         side_ff     <= side_in;
         heading_ff  <= heading_in;
         finished_ff <= finished_in;
      end
   end

   always_comb begin
      stat.heading  = heading_ff;
      stat.finished = finished_ff;
      stat.last     = !found && side_done;
   end

endmodule

`default_nettype wire

/* src/koch_curve_segment_generator.sv */
// Koch curve segment generator: one line segment per request.
// Usage:
//   csr_*  : register writes (index, data); always ready. Write only while idle.
//            0 depth, 1 mode, 2 start_x, 3 start_y, 4 base_length.
//   req_*  : one request per transfer; req_tdata[0] = restart. Restart reloads
//            the pen from the start point, scales the length and returns the
//            first segment; otherwise the next segment is returned.
//   rsp_*  : one segment per request. tdata = from_x, from_y, to_x, to_y
//            (Q16.16, from_x lowest); tlast marks the final segment; tuser
//            flags that no segment is left (all other bits zero).
// A plain request runs the step state; a restart first runs the divide state
//   once per depth level and the height state, as the single shared multiplier
//   divides the length by three once per cycle and then forms the height. One
//   request is in work at a time; req_tready returns once the segment is in the
//   output register, so a new request may enter while it waits.
// Stall: the segment holds in the output register until taken; the next
//   segment waits in the step state meanwhile.
// Reset: state idle, curve finished, response data not reset, rest cleared to zero.
// Depends on kcsg_pkg, kcsg_scale and kcsg_walker.
`default_nettype none

module koch_curve_segment_generator #(
   parameter int MAX_DEPTH   = kcsg_pkg::MaxDepthDefault,
   parameter int COORD_WIDTH = kcsg_pkg::CoordWidthDefault
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [kcsg_pkg::CsrIdxWidth-1:0]   csr_index,
   input  wire logic [31:0]                        csr_data,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [7:0]                         req_tdata,  // [0] restart
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [127:0]                            rsp_tdata,  // from_x, from_y, to_x, to_y
   output logic                                    rsp_tlast,  // last_segment
   output logic                                    rsp_tuser   // none_left
);

   localparam int DepthWidth = $clog2(MAX_DEPTH + 1);
   localparam int LenW       = kcsg_pkg::LenWidth;
   localparam int FW         = kcsg_pkg::FieldWidth;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_HEIGHT = 4'b0100,
      ST_STEP   = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [2:0]             depth_ff;
   logic                   mode_ff;
   logic [FW-1:0]          start_x_ff, start_y_ff;
   logic [LenW-1:0]        base_len_ff;
   logic [LenW-1:0]        len_ff, len_in;
   logic [LenW-1:0]        tall_ff, tall_in;
   logic [COORD_WIDTH-1:0] pen_x_ff, pen_x_in, pen_y_ff, pen_y_in;
   logic [DepthWidth-1:0]  cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [127:0]           rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_none_ff, rsp_none_in;

   logic [DepthWidth-1:0]  live_depth;
   kcsg_pkg::scale_op_type scale_op;
   logic [LenW-1:0]        scale_res;
   kcsg_pkg::walk_ctl_type walk_ctl;
   kcsg_pkg::walk_stat_type walk_stat;
   logic                   req_fire, step_fire;
   logic [LenW-1:0]        half;
   logic [COORD_WIDTH-1:0] dx, dy, next_x, next_y;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff    <= '0;
         mode_ff     <= 1'b0;
         start_x_ff  <= '0;
         start_y_ff  <= '0;
         base_len_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            kcsg_pkg::RegDepth:      depth_ff    <= csr_data[2:0];
            kcsg_pkg::RegMode:       mode_ff     <= csr_data[0];
            kcsg_pkg::RegStartX:     start_x_ff  <= csr_data;
            kcsg_pkg::RegStartY:     start_y_ff  <= csr_data;
            kcsg_pkg::RegBaseLength: base_len_ff <= csr_data[LenW-1:0];
            default: ;
         endcase
      end
   end

   // Depth beyond the digit counters acts as the deepest level
   always_comb begin
      if (32'(depth_ff) > 32'(MAX_DEPTH)) begin
         live_depth = DepthWidth'(MAX_DEPTH);
      end else begin
         live_depth = DepthWidth'(depth_ff);
      end
   end

   assign scale_op = (state_ff == ST_DIVIDE) ? kcsg_pkg::OP_DIV3 : kcsg_pkg::OP_HEIGHT;

   kcsg_scale u_scale (
      .op      (scale_op),
      .operand (len_ff),
      .result  (scale_res)
   );

   kcsg_walker #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_walker (
      .clock (clock),
      .reset (reset),
      .ctl   (walk_ctl),
      .depth (live_depth),
      .mode  (mode_ff),
      .stat  (walk_stat)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign step_fire  = (state_ff == ST_STEP) && (!rsp_valid_ff || rsp_tready);

   // Step vector for the current heading
   always_comb begin
      half = LenW'((32'(len_ff) + 32'd1) >> 1);
      unique case (walk_stat.heading)
         3'd0: begin
            dx = COORD_WIDTH'(len_ff);
            dy = '0;
         end
         3'd1: begin
            dx = COORD_WIDTH'(half);
            dy = COORD_WIDTH'(tall_ff);
         end
         3'd2: begin
            dx = '0 - COORD_WIDTH'(half);
            dy = COORD_WIDTH'(tall_ff);
         end
         3'd3: begin
            dx = '0 - COORD_WIDTH'(len_ff);
            dy = '0;
         end
         3'd4: begin
            dx = '0 - COORD_WIDTH'(half);
            dy = '0 - COORD_WIDTH'(tall_ff);
         end
         default: begin
            dx = COORD_WIDTH'(half);
            dy = '0 - COORD_WIDTH'(tall_ff);
         end
      endcase
      next_x = pen_x_ff + dx;
      next_y = pen_y_ff + dy;
   end

   always_comb begin
      state_in         = state_ff;
      len_in           = len_ff;
      tall_in          = tall_ff;
      pen_x_in         = pen_x_ff;
      pen_y_in         = pen_y_ff;
      cnt_in           = cnt_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_last_in      = rsp_last_ff;
      rsp_none_in      = rsp_none_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      walk_ctl.clear   = 1'b0;
      walk_ctl.advance = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tdata[0]) begin
                  len_in         = base_len_ff;
                  pen_x_in       = COORD_WIDTH'($signed(start_x_ff));
                  pen_y_in       = COORD_WIDTH'($signed(start_y_ff));
                  cnt_in         = '0;
                  walk_ctl.clear = 1'b1;
                  state_in       = (live_depth != '0) ? ST_DIVIDE : ST_HEIGHT;
               end else begin
                  state_in = ST_STEP;
               end
            end
         end
         ST_DIVIDE: begin
            len_in = scale_res;
            cnt_in = cnt_ff + 1'b1;
            if ((cnt_ff + 1'b1) == live_depth) begin
               state_in = ST_HEIGHT;
            end
         end
         ST_HEIGHT: begin
            tall_in  = scale_res;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (step_fire) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (walk_stat.finished) begin
                  rsp_data_in = '0;
                  rsp_last_in = 1'b0;
                  rsp_none_in = 1'b1;
               end else begin
                  rsp_data_in = {FW'(next_y), FW'(next_x), FW'(pen_y_ff), FW'(pen_x_ff)};
                  rsp_last_in = walk_stat.last;
                  rsp_none_in = 1'b0;
                  pen_x_in    = next_x;
                  pen_y_in    = next_y;
                  walk_ctl.advance = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         len_ff       <= '0;
         tall_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         len_ff       <= len_in;
         tall_ff      <= tall_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_none_ff <= rsp_none_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_none_ff;

endmodule

`default_nettype wire

/* src/kcsg_checker.sv */
// Port-level checks for the Koch curve segment generator, bound to its top level.
// Depends on koch_curve_segment_generator_assert.svh.
`default_nettype none
`include "koch_curve_segment_generator_assert.svh"

module kcsg_checker (
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          req_tvalid,
   input wire logic          req_tready,
   input wire logic          rsp_tvalid,
   input wire logic          rsp_tready,
   input wire logic [127:0]  rsp_tdata,
   input wire logic          rsp_tlast,
   input wire logic          rsp_tuser
);

   logic         req_xfer;
   logic         rsp_stall;
   logic         rsp_none;
   logic         rsp_clean;
   logic [129:0] rsp_word;

   assign req_xfer  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_none  = rsp_tvalid && rsp_tuser;
   assign rsp_clean = (rsp_tdata == '0) && !rsp_tlast;
   assign rsp_word  = {rsp_tdata, rsp_tlast, rsp_tuser};

   // An empty result carries no coordinates and no end mark
   `KCSG_ASSERT_NOW(a_none_left_clean, rsp_none, rsp_clean, "empty result carries data")

   // One request in work at a time
   `KCSG_ASSERT_NEXT(a_busy_after_req, req_xfer, !req_tready, "request taken while busy")

   // With no result pending, none appears in the cycle after the request transfer
   `KCSG_ASSERT_NEXT(a_no_early_rsp, req_xfer && !rsp_tvalid, !rsp_tvalid, "result too early")

   // Hold a stalled result
   `KCSG_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_word), "result not held")

endmodule

bind koch_curve_segment_generator kcsg_checker u_kcsg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
